// File: hdl/line_follow_pid_steering_core_defines.svh
// Assertion helpers for the steering core.
`ifndef LINE_FOLLOW_PID_STEERING_CORE_DEFINES_SVH
`define LINE_FOLLOW_PID_STEERING_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define LFPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define LFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/lfps_pkg.sv
package lfps_pkg;

  localparam int SUM_WIDTH_DEF = 16;
  localparam int PAT_W         = 5;
  localparam int ERR_W         = 4;
  localparam int SPEED_W       = 8;
  localparam int CFG_W         = 8;
  localparam int CFG_ADDR_W    = 3;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 24;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_LEFT_BASE  = 3'd3,
    REG_RIGHT_BASE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] gain_p;
    logic [CFG_W-1:0] gain_i;
    logic [CFG_W-1:0] gain_d;
    logic [CFG_W-1:0] left_base;
    logic [CFG_W-1:0] right_base;
  } cfg_t;

  // Sensor patterns, bit4 = leftmost sensor
  localparam logic [PAT_W-1:0] PAT_R4 = 5'b00001;
  localparam logic [PAT_W-1:0] PAT_R3 = 5'b00011;
  localparam logic [PAT_W-1:0] PAT_R2 = 5'b00010;
  localparam logic [PAT_W-1:0] PAT_R1 = 5'b00110;
  localparam logic [PAT_W-1:0] PAT_C0 = 5'b00100;
  localparam logic [PAT_W-1:0] PAT_L1 = 5'b01100;
  localparam logic [PAT_W-1:0] PAT_L2 = 5'b01000;
  localparam logic [PAT_W-1:0] PAT_L3 = 5'b11000;
  localparam logic [PAT_W-1:0] PAT_L4 = 5'b10000;

  function automatic logic signed [ERR_W-1:0] decode_pattern(
    input logic [PAT_W-1:0]        pat,
    input logic signed [ERR_W-1:0] keep
  );
    logic signed [ERR_W-1:0] e;
    unique case (pat)
      PAT_R4:  e = 4'sd4;
      PAT_R3:  e = 4'sd3;
      PAT_R2:  e = 4'sd2;
      PAT_R1:  e = 4'sd1;
      PAT_C0:  e = 4'sd0;
      PAT_L1:  e = -4'sd1;
      PAT_L2:  e = -4'sd2;
      PAT_L3:  e = -4'sd3;
      PAT_L4:  e = -4'sd4;
      default: e = keep;  // line lost or ambiguous: hold last error
    endcase
    return e;
  endfunction

endpackage

// File: hdl/lfps_err_track.sv
module lfps_err_track #(
  parameter int SUM_WIDTH = lfps_pkg::SUM_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic [lfps_pkg::PAT_W-1:0]           pattern,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic signed [lfps_pkg::ERR_W-1:0]    err,
  output logic signed [lfps_pkg::ERR_W:0]      deriv,
  output logic signed [SUM_WIDTH-1:0]          err_sum
);

  // err_r and sum_r double as the controller state: they only move when an item loads.
  logic                               vld_r;
  logic signed [lfps_pkg::ERR_W-1:0]  err_r;
  logic signed [lfps_pkg::ERR_W:0]    deriv_r;
  logic signed [SUM_WIDTH-1:0]        sum_r;

  logic signed [lfps_pkg::ERR_W-1:0]  err_nxt;
  logic signed [lfps_pkg::ERR_W:0]    deriv_nxt;
  logic signed [SUM_WIDTH:0]          sum_wide;
  logic signed [SUM_WIDTH-1:0]        sum_nxt;

  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    err_nxt   = lfps_pkg::decode_pattern(pattern, err_r);
    deriv_nxt = {err_nxt[lfps_pkg::ERR_W-1], err_nxt} - {err_r[lfps_pkg::ERR_W-1], err_r};
    sum_wide  = {sum_r[SUM_WIDTH-1], sum_r}
              + {{(SUM_WIDTH+1-lfps_pkg::ERR_W){err_nxt[lfps_pkg::ERR_W-1]}}, err_nxt};
    // overflow when the two top bits disagree; saturate toward the true sign
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_nxt = {sum_wide[SUM_WIDTH], {(SUM_WIDTH-1){!sum_wide[SUM_WIDTH]}}};
    end else begin
      sum_nxt = sum_wide[SUM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      err_r   <= '0;
      deriv_r <= '0;
      sum_r   <= '0;
    end else if (up_ready) begin
      vld_r <= up_valid;
      if (up_valid) begin
        err_r   <= err_nxt;
        deriv_r <= deriv_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  assign dn_valid = vld_r;
  assign err      = err_r;
  assign deriv    = deriv_r;
  assign err_sum  = sum_r;

endmodule

// File: hdl/lfps_pid_mul.sv
module lfps_pid_mul #(
  parameter int SUM_WIDTH = lfps_pkg::SUM_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lfps_pkg::cfg_t                        cfg,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic signed [lfps_pkg::ERR_W-1:0]     err,
  input  logic signed [lfps_pkg::ERR_W:0]       deriv,
  input  logic signed [SUM_WIDTH-1:0]           err_sum,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic signed [lfps_pkg::ERR_W+8:0]     p_prod,
  output logic signed [SUM_WIDTH+8:0]           i_prod,
  output logic signed [lfps_pkg::ERR_W+9:0]     d_prod,
  output logic signed [lfps_pkg::ERR_W-1:0]     err_out
);

  localparam int PW_P = lfps_pkg::ERR_W + 9;
  localparam int PW_I = SUM_WIDTH + 9;
  localparam int PW_D = lfps_pkg::ERR_W + 10;

  logic                               vld_r;
  logic signed [lfps_pkg::ERR_W+8:0]  p_r;
  logic signed [SUM_WIDTH+8:0]        i_r;
  logic signed [lfps_pkg::ERR_W+9:0]  d_r;
  logic signed [lfps_pkg::ERR_W-1:0]  err_r;

  logic signed [lfps_pkg::ERR_W+8:0]  p_nxt;
  logic signed [SUM_WIDTH+8:0]        i_nxt;
  logic signed [lfps_pkg::ERR_W+9:0]  d_nxt;

  assign up_ready = !vld_r || dn_ready;

  // gains are unsigned: a zero bit on top makes them signed operands
  assign p_nxt = PW_P'($signed({1'b0, cfg.gain_p})) * PW_P'(err);
  assign i_nxt = PW_I'($signed({1'b0, cfg.gain_i})) * PW_I'(err_sum);
  assign d_nxt = PW_D'($signed({1'b0, cfg.gain_d})) * PW_D'(deriv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      p_r   <= p_nxt;
      i_r   <= i_nxt;
      d_r   <= d_nxt;
      err_r <= err;
    end
  end

  assign dn_valid = vld_r;
  assign p_prod   = p_r;
  assign i_prod   = i_r;
  assign d_prod   = d_r;
  assign err_out  = err_r;

endmodule

// File: hdl/lfps_speed_out.sv
module lfps_speed_out #(
  parameter int SUM_WIDTH = lfps_pkg::SUM_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lfps_pkg::cfg_t                        cfg,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic signed [lfps_pkg::ERR_W+8:0]     p_prod,
  input  logic signed [SUM_WIDTH+8:0]           i_prod,
  input  logic signed [lfps_pkg::ERR_W+9:0]     d_prod,
  input  logic signed [lfps_pkg::ERR_W-1:0]     err,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lfps_pkg::SPEED_W-1:0]          left_speed,
  output logic [lfps_pkg::SPEED_W-1:0]          right_speed,
  output logic signed [lfps_pkg::ERR_W-1:0]     position_error
);

  localparam int PW = SUM_WIDTH + 11;
  localparam int SW = lfps_pkg::SPEED_W;

  logic                               vld_r;
  logic [SW-1:0]                      left_r;
  logic [SW-1:0]                      right_r;
  logic signed [lfps_pkg::ERR_W-1:0]  err_r;

  logic signed [PW-1:0]  pid;
  logic signed [PW:0]    lsum;
  logic signed [PW:0]    rdiff;
  logic [SW-1:0]         left_nxt;
  logic [SW-1:0]         right_nxt;

  assign up_ready = !vld_r || out_ready;

  always_comb begin
    pid   = PW'(p_prod) + PW'(i_prod) + PW'(d_prod);
    lsum  = $signed({{(PW+1-SW){1'b0}}, cfg.left_base}) + (PW+1)'(pid);
    rdiff = $signed({{(PW+1-SW){1'b0}}, cfg.right_base}) - (PW+1)'(pid);
    // left: clamp to 0..base; at or above base only when pid is non-negative
    if (!pid[PW-1]) begin
      left_nxt = cfg.left_base;
    end else if (lsum[PW]) begin
      left_nxt = '0;
    end else begin
      left_nxt = lsum[SW-1:0];
    end
    if (pid[PW-1] || (pid == '0)) begin
      right_nxt = cfg.right_base;
    end else if (rdiff[PW]) begin
      right_nxt = '0;
    end else begin
      right_nxt = rdiff[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      err_r   <= err;
    end
  end

  assign out_valid      = vld_r;
  assign left_speed     = left_r;
  assign right_speed    = right_r;
  assign position_error = err_r;

endmodule

// File: hdl/line_follow_pid_steering_core.sv
// Five-sensor line follower PID steering. Takes one transfer per cycle at full rate while
// the output is not stalled, and returns one result per sample through the input register,
// error/integral stage, product stage and sum-and-clamp output register. The full rate
// is set by the error and saturating-integral registers, which are read and
// rewritten in the same cycle for every sample. Backpressure is absorbed stage by
// stage, so a stalled output only stops the input once every stage holds an item.
// Registers: 0 gain_p, 1 gain_i, 2 gain_d, 3 left base speed, 4 right base speed;
// other indexes are ignored. Write them only while no samples are in flight.
`include "line_follow_pid_steering_core_defines.svh"

module line_follow_pid_steering_core #(
  parameter int SUM_WIDTH = lfps_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lfps_pkg::IN_TDATA_W-1:0]     in_tdata,   // [4:0] sensor_pattern
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] left_speed, [15:8] right_speed, [19:16] position_error
  output logic [lfps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [lfps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lfps_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int EW = lfps_pkg::ERR_W;

  lfps_pkg::cfg_t cfg_r;

  logic                      v0_r;
  logic [lfps_pkg::PAT_W-1:0] pat_r;

  logic                      s1_ready;
  logic                      s1_valid;
  logic signed [EW-1:0]      s1_err;
  logic signed [EW:0]        s1_deriv;
  logic signed [SUM_WIDTH-1:0] s1_sum;

  logic                      s2_ready;
  logic                      s2_valid;
  logic signed [EW+8:0]      s2_p;
  logic signed [SUM_WIDTH+8:0] s2_i;
  logic signed [EW+9:0]      s2_d;
  logic signed [EW-1:0]      s2_err;

  logic                      s3_ready;
  logic [lfps_pkg::SPEED_W-1:0] left_speed;
  logic [lfps_pkg::SPEED_W-1:0] right_speed;
  logic signed [EW-1:0]      position_error;

  logic                      s1_load;
  logic signed [EW:0]        s1_err_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lfps_pkg::REG_GAIN_P:     cfg_r.gain_p     <= cfg_wdata;
        lfps_pkg::REG_GAIN_I:     cfg_r.gain_i     <= cfg_wdata;
        lfps_pkg::REG_GAIN_D:     cfg_r.gain_d     <= cfg_wdata;
        lfps_pkg::REG_LEFT_BASE:  cfg_r.left_base  <= cfg_wdata;
        lfps_pkg::REG_RIGHT_BASE: cfg_r.right_base <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  assign in_tready = !v0_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_tready) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pat_r <= in_tdata[lfps_pkg::PAT_W-1:0];
    end
  end

  lfps_err_track #(.SUM_WIDTH(SUM_WIDTH)) u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v0_r),
    .up_ready (s1_ready),
    .pattern  (pat_r),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .err      (s1_err),
    .deriv    (s1_deriv),
    .err_sum  (s1_sum)
  );

  lfps_pid_mul #(.SUM_WIDTH(SUM_WIDTH)) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .err      (s1_err),
    .deriv    (s1_deriv),
    .err_sum  (s1_sum),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .p_prod   (s2_p),
    .i_prod   (s2_i),
    .d_prod   (s2_d),
    .err_out  (s2_err)
  );

  lfps_speed_out #(.SUM_WIDTH(SUM_WIDTH)) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .up_valid       (s2_valid),
    .up_ready       (s3_ready),
    .p_prod         (s2_p),
    .i_prod         (s2_i),
    .d_prod         (s2_d),
    .err            (s2_err),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .left_speed     (left_speed),
    .right_speed    (right_speed),
    .position_error (position_error)
  );

  assign out_tdata = {4'b0000, position_error, right_speed, left_speed};

  assign s1_load    = v0_r && s1_ready;
  assign s1_err_ext = {s1_err[EW-1], s1_err};

  `LFPS_ASSERT_NOW(a_err_range, out_tvalid, (position_error >= -4'sd4) && (position_error <= 4'sd4), "position error out of range")
  `LFPS_ASSERT_NEXT(a_deriv_chain, s1_load, s1_deriv == s1_err_ext - $past(s1_err_ext), "derivative not against previous error")
  `LFPS_ASSERT_NOW(a_no_bubble_stall, !in_tready, out_tvalid && !out_tready, "input stalled without output backpressure")

endmodule
